// File: hw/rtl/atip_pkg.sv
// ----------------------------------------------------------------------------
// atip_pkg: shared types and constants for the ASCII to int64 parser
// Field widths, status codes, character class and raw result structures.
// ----------------------------------------------------------------------------
package atip_pkg;

    localparam int CHAR_W   = 8;
    localparam int BASE_W   = 6;
    localparam int DIGIT_W  = 6;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 16;
    localparam int STATUS_W = 2;
    localparam int POS_BITS = 16;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [VALUE_W-1:0] MAG_POS = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] MAG_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd2;

    typedef struct packed {
        logic               is_ws;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               dig_valid;
        logic [DIGIT_W-1:0] dig;
    } t_char_class;

    typedef struct packed {
        logic [VALUE_W-1:0]  mag;
        logic                neg;
        logic [POS_BITS-1:0] stop;
        logic [STATUS_W-1:0] status;
        logic                found;
    } t_raw_result;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

endpackage

// File: hw/rtl/atip_if.sv
// ----------------------------------------------------------------------------
// atip_if: valid/ready channels of the ASCII to int64 parser
// Byte channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface atip_in_if
    import atip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_of_string;

    modport source (output valid, output char_code, output last_of_string, input ready);
    modport sink   (input valid, input char_code, input last_of_string, output ready);
endinterface

interface atip_out_if
    import atip_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  parsed_value;
    logic        [OFFSET_W-1:0] end_offset;
    logic        [STATUS_W-1:0] status;
    logic                       digits_found;

    modport source (output valid, output parsed_value, output end_offset,
                    output status, output digits_found, input ready);
    modport sink   (input valid, input parsed_value, input end_offset,
                    input status, input digits_found, output ready);
endinterface

// File: hw/rtl/atip_char_class.sv
// ----------------------------------------------------------------------------
// atip_char_class: byte classifier
// Flags whitespace, sign, zero and x, and decodes the digit value of a byte.
// ----------------------------------------------------------------------------
module atip_char_class
    import atip_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    output t_char_class       o_class
);

    logic [CHAR_W-1:0] num_off;
    logic [CHAR_W-1:0] up_off;
    logic [CHAR_W-1:0] low_off;
    logic              is_num;
    logic              is_up;
    logic              is_low;

    always_comb begin
        is_num  = (i_char >= 8'h30) && (i_char <= 8'h39);
        is_up   = (i_char >= 8'h41) && (i_char <= 8'h5A);
        is_low  = (i_char >= 8'h61) && (i_char <= 8'h7A);
        num_off = i_char - 8'h30;
        up_off  = i_char - 8'h37;   // 'A' maps to ten
        low_off = i_char - 8'h57;   // 'a' maps to ten

        o_class.is_ws     = (i_char == 8'h20) || ((i_char >= 8'd9) && (i_char <= 8'd13));
        o_class.is_minus  = (i_char == 8'h2D);
        o_class.is_plus   = (i_char == 8'h2B);
        o_class.is_zero   = (i_char == 8'h30);
        o_class.is_x      = (i_char == 8'h78) || (i_char == 8'h58);
        o_class.dig_valid = is_num || is_up || is_low;
        priority if (is_num) begin
            o_class.dig = num_off[DIGIT_W-1:0];
        end else if (is_up) begin
            o_class.dig = up_off[DIGIT_W-1:0];
        end else begin
            o_class.dig = low_off[DIGIT_W-1:0];
        end
    end

endmodule

// File: hw/rtl/atip_digit_acc.sv
// ----------------------------------------------------------------------------
// atip_digit_acc: multiply-add with saturation
// Computes acc * base + digit and clamps to the limit of the sign.
// ----------------------------------------------------------------------------
module atip_digit_acc
    import atip_pkg::*;
(
    input  logic [VALUE_W-1:0] i_acc,
    input  logic [BASE_W-1:0]  i_base,
    input  logic [DIGIT_W-1:0] i_digit,
    input  logic               i_neg,
    output logic               o_ovf,
    output logic [VALUE_W-1:0] o_acc
);

    localparam int SUM_W = VALUE_W + BASE_W + 1;

    logic [SUM_W-1:0]   prod;
    logic [SUM_W-1:0]   sum;
    logic [VALUE_W-1:0] lim;

    always_comb begin
        lim   = i_neg ? MAG_NEG : MAG_POS;
        prod  = SUM_W'(i_acc) * SUM_W'(i_base);
        sum   = prod + SUM_W'(i_digit);
        // exceeds the limit exactly when the divide-based test would trip
        o_ovf = sum > SUM_W'(lim);
        o_acc = o_ovf ? lim : sum[VALUE_W-1:0];
    end

endmodule

// File: hw/rtl/atip_result_fmt.sv
// ----------------------------------------------------------------------------
// atip_result_fmt: result formatter
// Applies the sign to the magnitude and trims the offset to the port width.
// ----------------------------------------------------------------------------
module atip_result_fmt
    import atip_pkg::*;
(
    input  t_raw_result                i_raw,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic        [OFFSET_W-1:0] o_offset,
    output logic        [STATUS_W-1:0] o_status,
    output logic                       o_found
);

    logic [VALUE_W-1:0] neg_mag;

    always_comb begin
        // the negative limit negates onto itself, so saturated values pass too
        neg_mag  = (~i_raw.mag) + VALUE_W'(1);
        o_value  = $signed(i_raw.neg ? neg_mag : i_raw.mag);
        o_offset = OFFSET_W'(i_raw.stop);
        o_status = i_raw.status;
        o_found  = i_raw.found;
    end

endmodule

// File: hw/rtl/ascii_to_int64_parser.sv
// ----------------------------------------------------------------------------
// ascii_to_int64_parser: streaming string to signed 64-bit integer
// Parses one byte per cycle while the input is not stalled, the way strtoll does,
// and emits one result word when the byte flagged last_of_string has been taken.
// ----------------------------------------------------------------------------
//
//   channel    direction  word                                handshake
//   i_char     in         char_code, last_of_string           valid/ready
//   o_result   out        parsed_value, end_offset, status,   valid/ready
//                         digits_found
//   i_cfg_*    in         number_base (6 bits)                write enable
//
// One byte is taken every cycle while the input is not stalled. The per-byte
// loop is the accumulator update: a 64 x 6 multiply, a digit add and a compare
// against the signed limit, all combinational on the parse state registers.
// After the last byte of a string is taken, the result word passes the input
// register, the state/raw result register and the formatted output register.
// The input stalls only when a last byte waits and both result registers are
// still full. Synchronous active-low reset clears all parse state and sets
// number_base to 0 (auto-detect). number_base is sampled on a string's first
// byte, so writes take effect on the next string.
//
module ascii_to_int64_parser
    import atip_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BASE_W-1:0] i_cfg_wr_data,
    atip_in_if.sink           i_char,
    atip_out_if.source        o_result
);

    // parse phases
    localparam logic [2:0] PH_WS     = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_HEX1   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // digit status
    localparam logic [1:0] DS_NONE = 2'd0;
    localparam logic [1:0] DS_DIG  = 2'd1;
    localparam logic [1:0] DS_OVF  = 2'd2;

    localparam logic [BASE_W-1:0] BASE_1   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_2   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_8   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_10  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_16  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

    // configuration
    logic [BASE_W-1:0] r_base_cfg;

    // input register
    logic              r_in_valid, n_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // parse state
    logic [2:0]          r_phase, n_phase;
    logic [VALUE_W-1:0]  r_acc,   n_acc;
    logic                r_neg,   n_neg;
    logic [BASE_W-1:0]   r_eff,   n_eff;
    logic [1:0]          r_ds,    n_ds;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic [POS_BITS-1:0] r_stop,  n_stop;

    // raw result and output registers
    logic        r_res_valid, n_res_valid;
    t_raw_result r_res,       n_res;
    logic        r_out_valid, n_out_valid;

    logic signed [VALUE_W-1:0]  r_out_value,  n_out_value;
    logic        [OFFSET_W-1:0] r_out_offset, n_out_offset;
    logic        [STATUS_W-1:0] r_out_status, n_out_status;
    logic                       r_out_found,  n_out_found;

    // handshake
    logic in_acc;
    logic out_free;
    logic res_free;
    logic res_to_out;
    logic step;

    // per-byte decode
    t_char_class       cls;
    logic [BASE_W-1:0] b_lat;
    logic              fc_zero;
    logic              fc_bad;
    logic [BASE_W-1:0] fc_base;
    logic              fc_dig_ok;
    logic              dp_ok;
    logic              take;
    logic [DIGIT_W-1:0] take_d;
    logic [BASE_W-1:0] mul_base;
    logic              acc_ovf;
    logic [VALUE_W-1:0] acc_next;
    logic              bad_base;

    atip_char_class u_class (
        .i_char  (r_in_char),
        .o_class (cls)
    );

    atip_digit_acc u_acc (
        .i_acc   (r_acc),
        .i_base  (mul_base),
        .i_digit (take_d),
        .i_neg   (r_neg),
        .o_ovf   (acc_ovf),
        .o_acc   (acc_next)
    );

    atip_result_fmt u_fmt (
        .i_raw    (r_res),
        .o_value  (n_out_value),
        .o_offset (n_out_offset),
        .o_status (n_out_status),
        .o_found  (n_out_found)
    );

    // handshake: the output register frees the raw result register, which
    // frees the input register only when a last byte has to leave a result
    always_comb begin
        out_free    = !r_out_valid || o_result.ready;
        res_to_out  = r_res_valid && out_free;
        res_free    = !r_res_valid || out_free;
        step        = r_in_valid && (!r_in_last || res_free);
        i_char.ready = !r_in_valid || step;
        in_acc      = i_char.valid && i_char.ready;

        n_in_valid  = in_acc ? 1'b1 : (step ? 1'b0 : r_in_valid);
        n_res_valid = (step && r_in_last) ? 1'b1 : (res_to_out ? 1'b0 : r_res_valid);
        n_out_valid = res_to_out ? 1'b1 : (o_result.ready ? 1'b0 : r_out_valid);
    end

    // parse step on the byte in the input register
    always_comb begin
        // sample the configured base on the first byte of a string
        b_lat = (r_pos == '0) ? r_base_cfg : r_eff;

        // first significant character, after whitespace and sign
        fc_zero   = ((b_lat == '0) || (b_lat == BASE_16)) && cls.is_zero;
        fc_bad    = (b_lat == BASE_1) || (b_lat > BASE_MAX);
        fc_base   = (b_lat == '0) ? BASE_10 : b_lat;
        fc_dig_ok = cls.dig_valid && (cls.dig < fc_base);
        dp_ok     = cls.dig_valid && (cls.dig < b_lat);

        n_phase = r_phase;
        n_eff   = b_lat;
        n_neg   = r_neg;
        take    = 1'b0;
        take_d  = cls.dig;

        unique case (r_phase)
            PH_WS, PH_FIRST: begin
                priority if ((r_phase == PH_WS) && cls.is_ws) begin
                    n_phase = PH_WS;
                end else if ((r_phase == PH_WS) && cls.is_minus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_FIRST;
                end else if ((r_phase == PH_WS) && cls.is_plus) begin
                    n_phase = PH_FIRST;
                end else if (fc_zero) begin
                    n_eff   = (b_lat == '0) ? BASE_8 : BASE_16;
                    n_phase = PH_ZERO;
                    take    = 1'b1;
                    take_d  = '0;
                end else if (fc_bad) begin
                    n_phase = PH_DONE;
                end else begin
                    n_eff   = fc_base;
                    n_phase = fc_dig_ok ? PH_DIGITS : PH_DONE;
                    take    = fc_dig_ok;
                end
            end
            PH_ZERO: begin
                if (cls.is_x) begin
                    n_eff   = BASE_16;
                    n_phase = PH_HEX1;
                end else begin
                    n_phase = dp_ok ? PH_DIGITS : PH_DONE;
                    take    = dp_ok;
                end
            end
            PH_HEX1, PH_DIGITS: begin
                n_phase = dp_ok ? PH_DIGITS : PH_DONE;
                take    = dp_ok;
            end
            default: begin
                // done: ignore bytes up to the end of the string
                n_phase = r_phase;
            end
        endcase

        mul_base = (n_eff < BASE_2) ? BASE_2 : n_eff;

        // digit accumulate; once saturated, only the stop offset advances
        n_stop = r_stop;
        n_ds   = r_ds;
        n_acc  = r_acc;
        if (take) begin
            n_stop = sat_inc(r_pos);
            if (r_ds != DS_OVF) begin
                n_ds  = acc_ovf ? DS_OVF : DS_DIG;
                n_acc = acc_next;
            end
        end
        n_pos = sat_inc(r_pos);

        // raw result from the updated state
        bad_base = (n_eff == BASE_1) || (n_eff > BASE_MAX);
        n_res    = '0;
        if (bad_base) begin
            n_res.status = ST_BAD_BASE;
        end else if (n_ds != DS_NONE) begin
            n_res.mag    = n_acc;
            n_res.neg    = n_neg;
            n_res.stop   = n_stop;
            n_res.status = (n_ds == DS_OVF) ? ST_RANGE : ST_OK;
            n_res.found  = 1'b1;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            r_base_cfg <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (in_acc) begin
            r_in_char <= i_char.char_code;
            r_in_last <= i_char.last_of_string;
        end
    end

    // parse state: advance on every step, clear after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (step && r_in_last)) begin
            r_phase <= PH_WS;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_eff   <= '0;
            r_ds    <= DS_NONE;
            r_pos   <= '0;
            r_stop  <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_eff   <= n_eff;
            r_ds    <= n_ds;
            r_pos   <= n_pos;
            r_stop  <= n_stop;
        end
    end

    // raw result and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
        end
        if (step && r_in_last) begin
            r_res <= n_res;
        end
        if (res_to_out) begin
            r_out_value  <= n_out_value;
            r_out_offset <= n_out_offset;
            r_out_status <= n_out_status;
            r_out_found  <= n_out_found;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.parsed_value = r_out_value;
    assign o_result.end_offset   = r_out_offset;
    assign o_result.status       = r_out_status;
    assign o_result.digits_found = r_out_found;

endmodule

// File: bench/ascii_to_int64_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_int64_parser_tb: self-checking bench for the string to int64 parser
// Streams strings into the byte channel and predicts one result word per
// string. Each received result word is compared with the oldest prediction.
// Directed strings cover whitespace, signs, prefixes, terminators and long
// strings. Random strings follow, under several radix settings and under
// different sender and receiver stall rates.
// ----------------------------------------------------------------------------
module ascii_to_int64_parser_tb;
    import atip_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_BYTES    = 125;
    localparam int MAX_PRINTS     = 100;
    localparam int LONG_RUN       = 60;

    // Parse phases of the predictor.
    typedef enum logic [2:0] {
        SCAN_WS, SCAN_FIRST, SCAN_ZERO, SCAN_HEX1, SCAN_DIGITS, SCAN_DONE
    } t_scan_phase;

    // Digit progress of the current string.
    typedef enum logic [1:0] {
        DIG_NONE, DIG_SEEN, DIG_OVERFLOW
    } t_digit_state;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_word;

    typedef struct {
        logic signed [VALUE_W-1:0]  value;
        logic        [OFFSET_W-1:0] offset;
        logic        [STATUS_W-1:0] status;
        logic                       found;
    } t_parse_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en;
    logic [BASE_W-1:0] i_cfg_wr_data;

    atip_in_if  char_ch ();
    atip_out_if result_ch ();

    ascii_to_int64_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char        (char_ch),
        .o_result      (result_ch)
    );

    always #2 i_clk = ~i_clk;

    // Bytes waiting to be sent and result words waiting to arrive.
    t_char_word    pending_bytes[$];
    t_parse_result expected_results[$];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    logic        hold_sender;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the parse state and the radix
    // register, advanced once per accepted byte.
    // ------------------------------------------------------------------------
    logic [BASE_W-1:0]   base_setting;
    t_scan_phase         scan_phase;
    logic [VALUE_W-1:0]  mag_acc;
    logic                is_negative;
    logic [BASE_W-1:0]   radix;
    t_digit_state        digit_state;
    logic [POS_BITS-1:0] byte_pos;
    logic [POS_BITS-1:0] stop_pos;

    function automatic void clear_scan();
        scan_phase  = SCAN_WS;
        mag_acc     = '0;
        is_negative = 1'b0;
        radix       = '0;
        digit_state = DIG_NONE;
        byte_pos    = '0;
        stop_pos    = '0;
    endfunction

    function automatic logic [POS_BITS-1:0] bump_pos(input logic [POS_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    // Digit weight of a byte; anything that is no digit in any radix maps to 99.
    function automatic int unsigned weight_of(input logic [CHAR_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h41 && c <= 8'h5A) return c - 8'h41 + 10;
        if (c >= 8'h61 && c <= 8'h7A) return c - 8'h61 + 10;
        return 99;
    endfunction

    function automatic void accumulate_digit(input int unsigned d);
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] b;
        lim = is_negative ? MAG_NEG : MAG_POS;
        b   = VALUE_W'(radix);
        stop_pos = bump_pos(byte_pos);
        if (digit_state == DIG_OVERFLOW) return;
        if (b < 2) b = 2;
        // Saturate once the next multiply-add would pass the signed limit.
        if (mag_acc > lim / b || (mag_acc == lim / b && VALUE_W'(d) > lim % b)) begin
            digit_state = DIG_OVERFLOW;
            mag_acc     = lim;
        end else begin
            digit_state = DIG_SEEN;
            mag_acc     = mag_acc * b + VALUE_W'(d);
        end
    endfunction

    function automatic void scan_digit(input logic [CHAR_W-1:0] c);
        int unsigned d;
        d = weight_of(c);
        if (d < radix) begin
            scan_phase = SCAN_DIGITS;
            accumulate_digit(d);
        end else begin
            scan_phase = SCAN_DONE;
        end
    endfunction

    function automatic void scan_first(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0] b;
        b = radix;
        if ((b == 0 || b == 16) && c == 8'h30) begin
            // A leading zero counts as a digit and may open a hex prefix.
            radix      = (b == 0) ? BASE_W'(8) : BASE_W'(16);
            scan_phase = SCAN_ZERO;
            accumulate_digit(0);
        end else if (b == 1 || b > 36) begin
            scan_phase = SCAN_DONE;
        end else begin
            if (b == 0) radix = BASE_W'(10);
            scan_digit(c);
        end
    endfunction

    // Advance the predictor by one accepted byte; queue a result on the last.
    function automatic void predict_byte(input logic [CHAR_W-1:0] c, input logic last);
        t_parse_result res;
        if (byte_pos == 0 && scan_phase == SCAN_WS && digit_state == DIG_NONE &&
            !is_negative && radix == 0)
            radix = base_setting;
        case (scan_phase)
            SCAN_WS: begin
                if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) begin
                    // skip leading whitespace
                end else if (c == 8'h2D) begin
                    is_negative = 1'b1;
                    scan_phase  = SCAN_FIRST;
                end else if (c == 8'h2B) begin
                    scan_phase = SCAN_FIRST;
                end else begin
                    scan_first(c);
                end
            end
            SCAN_FIRST: scan_first(c);
            SCAN_ZERO: begin
                if (c == 8'h78 || c == 8'h58) begin
                    radix      = BASE_W'(16);
                    scan_phase = SCAN_HEX1;
                end else begin
                    scan_digit(c);
                end
            end
            SCAN_HEX1, SCAN_DIGITS: scan_digit(c);
            default: ;
        endcase
        byte_pos = bump_pos(byte_pos);
        if (!last) return;

        res.value  = '0;
        res.offset = '0;
        res.status = ST_OK;
        res.found  = 1'b0;
        if (radix == 1 || radix > 36) begin
            res.status = ST_BAD_BASE;
        end else if (digit_state != DIG_NONE) begin
            res.found  = 1'b1;
            res.offset = OFFSET_W'(stop_pos);
            if (digit_state == DIG_OVERFLOW) begin
                res.status = ST_RANGE;
                res.value  = is_negative ? MAG_NEG : MAG_POS;
            end else begin
                res.value = is_negative ? -mag_acc : mag_acc;
            end
        end
        expected_results.push_back(res);
        clear_scan();
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predict each accepted word, then offer the next pending byte
    // unless the sender idles this cycle or is held off.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_word w;
        if (!i_rst_n) begin
            char_ch.valid <= 1'b0;
        end else begin
            if (char_ch.valid && char_ch.ready)
                predict_byte(char_ch.char_code, char_ch.last_of_string);
            if (!char_ch.valid || char_ch.ready) begin
                if (pending_bytes.size() != 0 && !hold_sender &&
                    $urandom_range(99) >= src_idle_pct) begin
                    w = pending_bytes.pop_front();
                    char_ch.valid          <= 1'b1;
                    char_ch.char_code      <= w.code;
                    char_ch.last_of_string <= w.last;
                end else begin
                    char_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result word against the oldest prediction,
    // then pick the ready level for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_parse_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with no prediction waiting");
                end else begin
                    want = expected_results.pop_front();
                    if (result_ch.parsed_value !== want.value)
                        report_mismatch($sformatf("parsed_value %0d, want %0d",
                                        result_ch.parsed_value, want.value));
                    if (result_ch.end_offset !== want.offset)
                        report_mismatch($sformatf("end_offset %0d, want %0d",
                                        result_ch.end_offset, want.offset));
                    if (result_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                        result_ch.status, want.status));
                    if (result_ch.digits_found !== want.found)
                        report_mismatch($sformatf("digits_found %0b, want %0b",
                                        result_ch.digits_found, want.found));
                end
            end
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Timeout: fail the run once the cycle count reaches the cycle limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("ascii_to_int64_parser_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
        if (d < 10) return CHAR_W'(8'h30 + d);
        return ($urandom_range(1) != 0) ? CHAR_W'(8'h61 + d - 10) : CHAR_W'(8'h41 + d - 10);
    endfunction

    function automatic logic [CHAR_W-1:0] space_char();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 5) ? 8'h20 : CHAR_W'(9 + k);
    endfunction

    // Queue one string; flag its final byte as the last.
    function automatic void queue_bytes(input logic [CHAR_W-1:0] s[$]);
        t_char_word w;
        foreach (s[i]) begin
            w.code = s[i];
            w.last = (i == s.size() - 1);
            pending_bytes.push_back(w);
        end
    endfunction

    function automatic void queue_text(input string txt);
        logic [CHAR_W-1:0] s[$];
        for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
        queue_bytes(s);
    endfunction

    // Build one random string for the given radix setting and queue it.
    // Most strings are well formed: optional whitespace, sign and prefix,
    // then either a boundary magnitude or a random digit run, then optional junk.
    function automatic int unsigned queue_random_string(input logic [BASE_W-1:0] base);
        logic [CHAR_W-1:0]  s[$];
        logic [CHAR_W-1:0]  digs[$];
        logic [VALUE_W-1:0] mag;
        logic [BASE_W-1:0]  eb;
        int unsigned        n;
        if ($urandom_range(99) < 12) begin
            // plain noise
            n = $urandom_range(1, 8);
            repeat (n) s.push_back(CHAR_W'($urandom_range(255)));
        end else begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) s.push_back(space_char());
            case ($urandom_range(2))
                1: s.push_back(8'h2B);
                2: s.push_back(8'h2D);
                default: ;
            endcase
            eb = base;
            if ((base == 0 || base == 16) && $urandom_range(2) == 0) begin
                s.push_back(8'h30);
                s.push_back(($urandom_range(1) != 0) ? 8'h78 : 8'h58);
                eb = BASE_W'(16);
            end else if (base == 0 && $urandom_range(3) == 0) begin
                s.push_back(8'h30);
                eb = BASE_W'(8);
            end else if (base == 0) begin
                eb = BASE_W'(10);
            end
            // Under an invalid radix, send decimal text anyway.
            if (eb < 2 || eb > 36) eb = BASE_W'(10);
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(6))
                    0: mag = MAG_POS;
                    1: mag = MAG_NEG;
                    2: mag = MAG_POS - 1;
                    3: mag = MAG_NEG + 1;
                    4: mag = '1;
                    5: mag = VALUE_W'($urandom_range(1000));
                    default: mag = {$urandom, $urandom};
                endcase
                while (mag != 0) begin
                    digs.push_front(digit_char(int'(mag % VALUE_W'(eb))));
                    mag = mag / VALUE_W'(eb);
                end
                if (digs.size() == 0) digs.push_back(8'h30);
                foreach (digs[i]) s.push_back(digs[i]);
            end else begin
                n = ($urandom_range(15) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 6);
                repeat (n) s.push_back(digit_char($urandom_range(eb - 1)));
            end
            if ($urandom_range(1) != 0) begin
                s.push_back(CHAR_W'($urandom_range(255)));
                repeat ($urandom_range(0, 3)) s.push_back(CHAR_W'($urandom_range(255)));
            end
            if (s.size() == 0) s.push_back(digit_char($urandom_range(eb - 1)));
        end
        queue_bytes(s);
        return s.size();
    endfunction

    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
            default: begin src_idle_pct = 9; sink_stall_pct = 9; end
        endcase
    endtask

    // Wait until every byte is taken and every result word has arrived,
    // then let the pipeline settle.
    task automatic drain_stream();
        while (pending_bytes.size() != 0 || char_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the radix register; the block is idle here.
    task automatic write_base(input logic [BASE_W-1:0] b);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= b;
        base_setting   = b;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [CHAR_W-1:0] one[$];
        logic [BASE_W-1:0] phase_base [RANDOM_PHASES];
        int unsigned       sent;
        int unsigned       half;
        t_char_word        w;

        // Hold every block input at a known level from time zero.
        char_ch.valid          = 1'b0;
        char_ch.char_code      = '0;
        char_ch.last_of_string = 1'b0;
        result_ch.ready        = 1'b0;
        i_cfg_wr_en            = 1'b0;
        i_cfg_wr_data          = '0;
        hold_sender            = 1'b0;
        mismatch_count         = 0;
        cycle_count            = 0;
        base_setting           = '0;
        clear_scan();
        set_idling(0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings under the reset radix (auto-detect).
        queue_text("\t-0x1F");         // whitespace, minus, hex prefix
        queue_text("0x");              // bare prefix converts only the zero
        queue_text("+017z9");          // octal, terminator, ignored tail
        one = '{8'h00};                // NUL alone: no digits
        queue_bytes(one);
        one = '{8'hFF};
        queue_bytes(one);
        queue_text(" -");              // sign with no digits
        one = '{8'h30, 8'h00, 8'h35};  // NUL ends the number, rest ignored
        queue_bytes(one);
        // Long string: a run of whitespace ahead of the digits.
        w.code = 8'h20;
        w.last = 1'b0;
        repeat (LONG_RUN) pending_bytes.push_back(w);
        queue_text("12");
        drain_stream();

        // Short directed strings under invalid radix settings.
        write_base(BASE_W'(63));
        queue_text(" -12");
        drain_stream();
        write_base(BASE_W'(1));
        drain_stream();
        queue_text("+7");
        drain_stream();

        phase_base = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd8, 6'd63, 6'd0,
                       6'd1, 6'd37, 6'd16, 6'd0, 6'd10, 6'd0, 6'd0};
        phase_base[12] = BASE_W'($urandom_range(63));
        phase_base[13] = BASE_W'($urandom_range(2, 36));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_base(phase_base[p]);
            set_idling(p);
            sent = 0;
            while (sent < PHASE_BYTES) sent += queue_random_string(phase_base[p]);
            if (p == 1) begin
                // Hold off the sender midway until the results catch up.
                half = pending_bytes.size() / 2;
                while (pending_bytes.size() > half) @(posedge i_clk);
                hold_sender <= 1'b1;
                @(posedge i_clk);
                while (char_ch.valid || expected_results.size() != 0) @(posedge i_clk);
                hold_sender <= 1'b0;
            end
            drain_stream();
        end

        if (mismatch_count == 0) begin
            $display("ascii_to_int64_parser_tb: PASS");
        end else begin
            $display("ascii_to_int64_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
